// ===== sv/rars_pkg.sv =====
// Shared types and constants of the ring allreduce chunk scheduler.
package rars_pkg;

  localparam int CHUNK_W = 6;
  localparam int STEP_W  = 7;
  localparam int RCV_W   = 7;
  localparam int WC_W    = 7;
  localparam int RANK_W  = 6;
  localparam int CNT_W   = 3;
  localparam int ACT_W   = 2;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  // Remainder unit: dividend below 4*127 + 63, two restoring steps a cycle.
  localparam int DIV_W     = 10;
  localparam int MOD_K_W   = 4;
  localparam logic [MOD_K_W-1:0] MOD_K0     = MOD_K_W'(DIV_W - 1);
  localparam logic [MOD_K_W-1:0] MOD_K_LAST = MOD_K_W'(1);
  localparam logic [MOD_K_W-1:0] MOD_K_DEC  = MOD_K_W'(2);

  localparam logic [WC_W-1:0]  WC_RESET  = WC_W'(8);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(7);
  localparam logic [CNT_W-1:0] CNT_LATE  = CNT_W'(2);
  localparam logic [RCV_W-1:0] RCV_MAX   = RCV_W'(127);
  localparam int               RANK_OFS  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_RANK    = CFG_IDX_W'(1);

  typedef enum logic [ACT_W-1:0] {
    ACT_START = 2'd0,
    ACT_SENT  = 2'd1,
    ACT_RECV  = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef enum logic {MOD_INIT, MOD_SEND} mod_sel_t;
  typedef enum logic {ADDR_RCHUNK, ADDR_IDX} addr_sel_t;
  typedef enum logic {WR_ONE, WR_INC} wr_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_MOD,
    ST_INIT_WR,
    ST_RECV_RD,
    ST_RECV_WR,
    ST_TRY,
    ST_TRY_MOD,
    ST_TRY_CHK,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic      load_item;
    logic      clear_all;
    logic      clr_busy;
    logic      rcv_inc;
    logic      mod_start;
    mod_sel_t  mod_sel;
    logic      mem_rd;
    logic      mem_wr;
    addr_sel_t addr_sel;
    wr_sel_t   wr_sel;
    logic      send_issue;
    logic      out_load;
  } rars_cmd_t;

  typedef struct packed {
    logic mod_busy;
    logic rchunk_ok;
    logic can_try;
    logic cnt_lt_max;
    logic chunk_ready;
    logic out_free;
  } rars_sts_t;

endpackage

// ===== sv/rars_in_if.sv =====
// Request channel of the scheduler: one event per request.
interface rars_in_if;
  import rars_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [CHUNK_W-1:0] received_chunk;

  modport source (output valid, output action, output received_chunk, input ready);
  modport sink   (input valid, input action, input received_chunk, output ready);
endinterface

// ===== sv/rars_out_if.sv =====
// Result channel of the scheduler: one send decision per request.
interface rars_out_if;
  import rars_pkg::*;

  logic               valid;
  logic               ready;
  logic               send_now;
  logic [CHUNK_W-1:0] send_chunk;
  logic [STEP_W-1:0]  send_step;
  logic               all_received;

  modport source (output valid, output send_now, output send_chunk, output send_step,
                  output all_received, input ready);
  modport sink   (input valid, input send_now, input send_chunk, input send_step,
                  input all_received, output ready);
endinterface

// ===== sv/rars_ram.sv =====
// Generic single write port RAM with registered read.
module rars_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== sv/rars_mod.sv =====
// Iterative remainder unit: two restoring subtract steps per cycle.
module rars_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rars_pkg::DIV_W-1:0] dividend,
  input  logic [rars_pkg::WC_W-1:0]  divisor,
  output logic                      busy,
  output logic [rars_pkg::WC_W-1:0]  rem
);
  import rars_pkg::*;

  localparam int WW = DIV_W + WC_W;

  logic [DIV_W-1:0]   rem_r;
  logic [WC_W-1:0]    dsr_r;
  logic [MOD_K_W-1:0] k_r;
  logic               busy_r;
  logic [WW-1:0]      rem_w, sh_hi, sh_lo, mid, rem_nxt;

  always_comb begin
    rem_w   = WW'(rem_r);
    sh_hi   = WW'(dsr_r) << k_r;
    sh_lo   = WW'(dsr_r) << (k_r - MOD_K_W'(1));
    mid     = (rem_w >= sh_hi) ? rem_w - sh_hi : rem_w;
    rem_nxt = (mid >= sh_lo) ? mid - sh_lo : mid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && k_r == MOD_K_LAST) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsr_r <= divisor;
      k_r   <= MOD_K0;
    end else if (busy_r) begin
      rem_r <= DIV_W'(rem_nxt);
      k_r   <= k_r - MOD_K_DEC;
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r[WC_W-1:0];
endmodule

// ===== sv/rars_dp.sv =====
// Datapath: configuration, counters, chunk count store, remainder unit, result register.
module rars_dp #(
  parameter int MAX_WORKERS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rars_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rars_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [rars_pkg::CHUNK_W-1:0]   in_rchunk,
  input  rars_pkg::rars_cmd_t            cmd,
  output rars_pkg::rars_sts_t            sts,
  rars_out_if.source                     out_chan
);
  import rars_pkg::*;

  localparam int IDX_W = $clog2(MAX_WORKERS);

  logic [WC_W-1:0]    wc_r;
  logic [RANK_W-1:0]  rank_r;
  logic [STEP_W-1:0]  step_r;
  logic [RCV_W-1:0]   rcv_r;
  logic               busy_r;
  logic [CHUNK_W-1:0] rchunk_r;
  logic               sent_r;
  logic [CHUNK_W-1:0] sch_r;
  logic [STEP_W-1:0]  sst_r;
  logic [MAX_WORKERS-1:0] vld_r;
  logic               rd_vld_r;

  logic               out_valid_r;
  logic               out_send_r;
  logic [CHUNK_W-1:0] out_chunk_r;
  logic [STEP_W-1:0]  out_step_r;
  logic               out_all_r;

  logic [WC_W-1:0]    n;
  logic [WC_W:0]      lim;
  logic [DIV_W-1:0]   dividend;
  logic [WC_W-1:0]    mod_rem;
  logic               mod_busy;
  logic [IDX_W-1:0]   addr;
  logic [CNT_W-1:0]   rd_data;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   wr_data;
  logic               all_rcv;

  // Effective ring size, clamped to one and to the store depth.
  always_comb begin
    if (wc_r == '0) begin
      n = WC_W'(1);
    end else if (int'(wc_r) > MAX_WORKERS) begin
      n = WC_W'(MAX_WORKERS);
    end else begin
      n = wc_r;
    end
  end

  assign lim     = {n, 1'b0} - (WC_W + 1)'(1);
  assign all_rcv = {1'b0, rcv_r} >= lim;

  always_comb begin
    case (cmd.mod_sel)
      MOD_INIT: dividend = DIV_W'({n, 1'b0}) + DIV_W'(rank_r) - DIV_W'(RANK_OFS);
      default:  dividend = DIV_W'({n, 2'b00}) + DIV_W'(rank_r) - DIV_W'(RANK_OFS)
                           - DIV_W'(step_r);
    endcase
  end

  rars_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (dividend),
    .divisor  (n),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  assign addr    = (cmd.addr_sel == ADDR_IDX) ? IDX_W'(mod_rem) : IDX_W'(rchunk_r);
  // An entry not written since start reads as zero.
  assign cnt     = rd_vld_r ? rd_data : '0;
  assign wr_data = (cmd.wr_sel == WR_ONE) ? CNT_W'(1) : cnt + CNT_W'(1);

  rars_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_WORKERS)
  ) u_counts (
    .clk   (clk),
    .we    (cmd.mem_wr),
    .waddr (addr),
    .wdata (wr_data),
    .re    (cmd.mem_rd),
    .raddr (addr),
    .rdata (rd_data)
  );

  always_comb begin
    sts.mod_busy    = mod_busy;
    sts.rchunk_ok   = {1'b0, rchunk_r} < n;
    sts.can_try     = !busy_r && ({1'b0, step_r} < lim);
    sts.cnt_lt_max  = cnt != CNT_MAX;
    sts.chunk_ready = (step_r < n) ? (cnt != '0) : (cnt == CNT_LATE);
    sts.out_free    = !out_valid_r || out_chan.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r   <= WC_RESET;
      rank_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WORKER_COUNT: wc_r   <= cfg_wdata;
        CFG_NODE_RANK:    rank_r <= cfg_wdata[RANK_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      rcv_r    <= '0;
      busy_r   <= 1'b0;
      sent_r   <= 1'b0;
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.clear_all) begin
        step_r <= '0;
        rcv_r  <= '0;
        busy_r <= 1'b0;
        vld_r  <= '0;
      end
      if (cmd.clr_busy) begin
        busy_r <= 1'b0;
      end
      if (cmd.rcv_inc && rcv_r != RCV_MAX) begin
        rcv_r <= rcv_r + RCV_W'(1);
      end
      if (cmd.load_item) begin
        sent_r <= 1'b0;
      end
      if (cmd.mem_wr) begin
        vld_r[addr] <= 1'b1;
      end
      if (cmd.mem_rd) begin
        rd_vld_r <= vld_r[addr];
      end
      if (cmd.send_issue) begin
        busy_r <= 1'b1;
        step_r <= step_r + STEP_W'(1);
        sent_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      rchunk_r <= in_rchunk;
    end
    if (cmd.send_issue) begin
      sch_r <= CHUNK_W'(mod_rem);
      sst_r <= step_r;
    end
  end

  // Result register: hold until taken, refill only when free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_send_r  <= sent_r;
      out_chunk_r <= sent_r ? sch_r : '0;
      out_step_r  <= sent_r ? sst_r : '0;
      out_all_r   <= all_rcv;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.send_now     = out_send_r;
  assign out_chan.send_chunk   = out_chunk_r;
  assign out_chan.send_step    = out_step_r;
  assign out_chan.all_received = out_all_r;
endmodule

// ===== sv/rars_ctrl.sv =====
// Controller: sequences one request through update, send attempt and result.
module rars_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [rars_pkg::ACT_W-1:0]      in_action,
  output logic                            in_ready,
  input  rars_pkg::rars_sts_t             sts,
  output rars_pkg::rars_cmd_t             cmd
);
  import rars_pkg::*;

  st_t  state_r, state_nxt;
  act_t act;

  assign act = act_t'(in_action);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (act)
            ACT_START: state_nxt = ST_INIT_MOD;
            ACT_SENT:  state_nxt = ST_TRY;
            ACT_RECV:  state_nxt = ST_RECV_RD;
            ACT_NONE:  state_nxt = ST_OUT;
          endcase
        end
      end
      ST_INIT_MOD: if (!sts.mod_busy) state_nxt = ST_INIT_WR;
      ST_INIT_WR:  state_nxt = ST_TRY;
      ST_RECV_RD:  state_nxt = sts.rchunk_ok ? ST_RECV_WR : ST_TRY;
      ST_RECV_WR:  state_nxt = ST_TRY;
      ST_TRY:      state_nxt = sts.can_try ? ST_TRY_MOD : ST_OUT;
      ST_TRY_MOD:  if (!sts.mod_busy) state_nxt = ST_TRY_CHK;
      ST_TRY_CHK:  state_nxt = ST_OUT;
      ST_OUT:      if (sts.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          unique case (act)
            ACT_START: begin
              cmd.clear_all = 1'b1;
              cmd.mod_start = 1'b1;
              cmd.mod_sel   = MOD_INIT;
            end
            ACT_SENT: cmd.clr_busy = 1'b1;
            ACT_RECV: cmd.rcv_inc  = 1'b1;
            ACT_NONE: ;
          endcase
        end
      end
      ST_INIT_WR: begin
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = ADDR_IDX;
        cmd.wr_sel   = WR_ONE;
      end
      ST_RECV_RD: begin
        cmd.mem_rd   = sts.rchunk_ok;
        cmd.addr_sel = ADDR_RCHUNK;
      end
      ST_RECV_WR: begin
        // Saturate the count: drop the write once it has reached the top.
        cmd.mem_wr   = sts.cnt_lt_max;
        cmd.addr_sel = ADDR_RCHUNK;
        cmd.wr_sel   = WR_INC;
      end
      ST_TRY: begin
        cmd.mod_start = sts.can_try;
        cmd.mod_sel   = MOD_SEND;
      end
      ST_TRY_MOD: begin
        cmd.mod_sel  = MOD_SEND;
        cmd.mem_rd   = !sts.mod_busy;
        cmd.addr_sel = ADDR_IDX;
      end
      ST_TRY_CHK: begin
        cmd.addr_sel   = ADDR_IDX;
        cmd.send_issue = sts.chunk_ready;
      end
      ST_OUT: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end
endmodule

// ===== sv/ring_allreduce_chunk_scheduler.sv =====
// Top level of the ring allreduce chunk scheduler.
// Each request (start, send completed, chunk received) updates the scheduler
// state and then tries one send; exactly one result comes back per request,
// carrying the send decision and whether the whole ring has been received; an
// unused action code only returns a result. Requests are handled one at a
// time. The chunk index mod the ring size comes from an iterative remainder
// unit that runs once for a send attempt and once more for a start; the count
// store is a RAM with registered read. Results wait in an output register, so a
// new request is taken while the previous result is still pending. Write
// configuration only while no request is in progress.
module ring_allreduce_chunk_scheduler #(
  parameter int MAX_WORKERS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rars_in_if.sink                       in_chan,
  rars_out_if.source                    out_chan,
  input  logic                          cfg_we,
  input  logic [rars_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rars_pkg::CFG_W-1:0]     cfg_wdata
);
  import rars_pkg::*;

  rars_cmd_t cmd;
  rars_sts_t sts;
  logic      in_ready;

  rars_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rars_dp #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_rchunk (in_chan.received_chunk),
    .cmd       (cmd),
    .sts       (sts),
    .out_chan  (out_chan)
  );

  assign in_chan.ready = in_ready;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request accepted while previous one still in progress");

  a_no_send_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.send_now) |->
      (out_chan.send_chunk == '0 && out_chan.send_step == '0))
    else $error("result without a send carries chunk or step");

  a_send_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.send_issue |-> (sts.chunk_ready && !cmd.mem_wr && !sts.mod_busy))
    else $error("send issued without a settled ready count");

  a_single_mem_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_wr && cmd.mem_rd))
    else $error("count store read and written in one cycle");
endmodule

// ===== tb/allreduce_sched_checker.sv =====
// Checker for the chunk scheduler: tracks each request, predicts its send decision, compares.
`timescale 1ns / 100ps
module allreduce_sched_checker #(
  parameter int MAX_WORKERS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rars_in_if                             in_mon,
  rars_out_if                            out_mon,
  input  logic                           cfg_we,
  input  logic [rars_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rars_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             mismatches,
  output int                             outstanding,
  output int                             sends_seen,
  output int                             results_seen
);
  import rars_pkg::*;

  typedef struct packed {
    logic               send_now;
    logic [CHUNK_W-1:0] send_chunk;
    logic [STEP_W-1:0]  send_step;
    logic               all_received;
  } decision_t;

  logic [CNT_W-1:0]  chunk_cnt [MAX_WORKERS];
  logic [STEP_W-1:0] step_ctr;
  logic [RCV_W-1:0]  rcv_ctr;
  logic              in_flight;
  logic [WC_W-1:0]   workers;
  logic [RANK_W-1:0] rank;

  decision_t decisions_due[$];
  int        n_bad;
  int        n_sends;
  int        n_results;

  function automatic int ring_n();
    if (workers == '0) return 1;
    if (int'(workers) > MAX_WORKERS) return MAX_WORKERS;
    return int'(workers);
  endfunction

  // Issue the next send of the ring schedule if nothing is in flight and its chunk is ready.
  function automatic bit try_issue(input int n, output int chunk, output int step);
    int   s;
    int   idx;
    logic ok;
    chunk = 0;
    step  = 0;
    s = int'(step_ctr);
    if (in_flight || s >= 2 * n - 1) return 1'b0;
    idx = (4 * n + int'(rank) - 2 - s) % n;
    // reduce-scatter steps take any nonzero count; allgather steps need exactly two
    if (s <= n - 1) ok = (chunk_cnt[idx] >= CNT_W'(1));
    else            ok = (chunk_cnt[idx] == CNT_LATE);
    if (!ok) return 1'b0;
    in_flight = 1'b1;
    chunk     = idx;
    step      = s;
    step_ctr  = STEP_W'(s + 1);
    return 1'b1;
  endfunction

  function automatic decision_t predict_decision(input act_t act,
                                                 input logic [CHUNK_W-1:0] rchunk);
    int        n;
    int        chunk;
    int        step;
    bit        sent;
    decision_t d;
    n     = ring_n();
    chunk = 0;
    step  = 0;
    sent  = 1'b0;
    case (act)
      ACT_START: begin
        foreach (chunk_cnt[i]) chunk_cnt[i] = '0;
        step_ctr  = '0;
        rcv_ctr   = '0;
        in_flight = 1'b0;
        chunk_cnt[(2 * n + int'(rank) - 2) % n] = CNT_W'(1);
        sent = try_issue(n, chunk, step);
      end
      ACT_SENT: begin
        in_flight = 1'b0;
        sent = try_issue(n, chunk, step);
      end
      ACT_RECV: begin
        if (rcv_ctr < RCV_MAX) rcv_ctr = rcv_ctr + RCV_W'(1);
        // chunks outside the ring still count as messages
        if (int'(rchunk) < n && chunk_cnt[rchunk] < CNT_MAX)
          chunk_cnt[rchunk] = chunk_cnt[rchunk] + CNT_W'(1);
        sent = try_issue(n, chunk, step);
      end
      default: ;
    endcase
    d.send_now     = sent;
    d.send_chunk   = sent ? CHUNK_W'(chunk) : '0;
    d.send_step    = sent ? STEP_W'(step) : '0;
    d.all_received = (int'(rcv_ctr) >= 2 * n - 1);
    return d;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_bad++;
    end
  endtask

  always @(posedge clk) begin : watch
    decision_t want;
    decision_t got;
    if (!rst_n) begin
      foreach (chunk_cnt[i]) chunk_cnt[i] = '0;
      step_ctr  = '0;
      rcv_ctr   = '0;
      in_flight = 1'b0;
      workers   = WC_RESET;
      rank      = '0;
      decisions_due.delete();
      n_bad     = 0;
      n_sends   = 0;
      n_results = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WORKER_COUNT) workers = cfg_wdata[WC_W-1:0];
        else                               rank    = cfg_wdata[RANK_W-1:0];
      end
      if (in_mon.valid && in_mon.ready)
        decisions_due.push_back(predict_decision(act_t'(in_mon.action),
                                                 in_mon.received_chunk));
      if (out_mon.valid && out_mon.ready) begin
        got.send_now     = out_mon.send_now;
        got.send_chunk   = out_mon.send_chunk;
        got.send_step    = out_mon.send_step;
        got.all_received = out_mon.all_received;
        n_results++;
        if (got.send_now === 1'b1) n_sends++;
        if (decisions_due.size() == 0) begin
          $display("%0t: result with no request waiting, expected none, actual %0d/%0d/%0d/%0d",
                   $time, got.send_now, got.send_chunk, got.send_step, got.all_received);
          n_bad++;
        end else begin
          want = decisions_due.pop_front();
          check_field("send_now", 32'(want.send_now), 32'(got.send_now));
          check_field("send_chunk", 32'(want.send_chunk), 32'(got.send_chunk));
          check_field("send_step", 32'(want.send_step), 32'(got.send_step));
          check_field("all_received", 32'(want.all_received), 32'(got.all_received));
        end
      end
    end
    mismatches   <= n_bad;
    outstanding  <= decisions_due.size();
    sends_seen   <= n_sends;
    results_seen <= n_results;
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the scheduler testbench: clock, reset, requests, result stalls and verdict.
`timescale 1ns / 100ps
module testbench;
  import rars_pkg::*;

  localparam int MAX_WORKERS = 64;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_COMB, STALL_HEAVY} stall_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  rars_in_if  in_chan ();
  rars_out_if out_chan ();

  int mismatches;
  int outstanding;
  int sends_seen;
  int results_seen;

  int burst_left;
  int requests_sent;
  int settings_used;
  int cur_n;
  int cur_rank;

  always #5 clk = ~clk;

  ring_allreduce_chunk_scheduler #(.MAX_WORKERS(MAX_WORKERS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  allreduce_sched_checker #(.MAX_WORKERS(MAX_WORKERS)) sched_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .sends_seen   (sends_seen),
    .results_seen (results_seen)
  );

  // Present one request and hold it until taken; then continue the burst or open a gap.
  task automatic issue(input act_t act, input logic [CHUNK_W-1:0] chunk);
    int gap;
    in_chan.valid          <= 1'b1;
    in_chan.action         <= act;
    in_chan.received_chunk <= chunk;
    do @(posedge clk); while (!in_chan.ready);
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 6);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off until every result has come back, then let the block settle.
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_ring(input int wc, input int rd);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WORKER_COUNT;
    cfg_wdata <= CFG_W'(wc);
    @(posedge clk);
    cfg_index <= CFG_NODE_RANK;
    cfg_wdata <= CFG_W'(rd);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_n    = (wc == 0) ? 1 : (wc > MAX_WORKERS) ? MAX_WORKERS : wc;
    cur_rank = rd & 63;
    settings_used++;
  endtask

  // Chunk that the left neighbour sends at its step j.
  function automatic logic [CHUNK_W-1:0] neighbour_chunk(input int j);
    return CHUNK_W'((4 * cur_n + cur_rank - 3 - j) % cur_n);
  endfunction

  // Mostly a proper ring exchange with random interleaving, plus stray and broken requests.
  task automatic run_phase(input int wc, input int rd, input int items);
    int j;
    int r;
    int k;
    set_ring(wc, rd);
    issue(ACT_START, CHUNK_W'($urandom));
    j = 0;
    for (k = 1; k < items; k++) begin
      r = $urandom_range(0, 99);
      if ((j >= 2 * cur_n - 1 && r < 15) || $urandom_range(0, 40 * cur_n) == 0) begin
        issue(ACT_START, CHUNK_W'($urandom));
        j = 0;
      end else if (r < 45 && j < 2 * cur_n - 1) begin
        issue(ACT_RECV, neighbour_chunk(j));
        j++;
      end else if (r < 82) begin
        issue(ACT_SENT, CHUNK_W'($urandom));
      end else if (r < 89) begin
        issue(ACT_RECV, CHUNK_W'($urandom));
      end else if (r < 94) begin
        issue(ACT_RECV, neighbour_chunk((j == 0) ? 0 : j - 1));
      end else begin
        issue(ACT_NONE, CHUNK_W'($urandom));
      end
    end
  endtask

  initial begin : result_stalls
    stall_t mode;
    int     span;
    int     period;
    int     phase;
    out_chan.ready <= 1'b0;
    forever begin
      mode   = stall_t'($urandom_range(0, 3));
      span   = $urandom_range(16, 96);
      period = $urandom_range(2, 9);
      for (phase = 0; phase < span; phase++) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:   out_chan.ready <= 1'b1;
          STALL_RANDOM: out_chan.ready <= ($urandom_range(0, 3) != 0);
          STALL_COMB:   out_chan.ready <= ((phase % period) == 0);
          default:      out_chan.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    in_chan.valid          <= 1'b0;
    in_chan.action         <= ACT_NONE;
    in_chan.received_chunk <= '0;
    cfg_we                 <= 1'b0;
    cfg_index              <= CFG_WORKER_COUNT;
    cfg_wdata              <= '0;
    rst_n                  <= 1'b0;
    burst_left    = 0;
    requests_sent = 0;
    settings_used = 1;
    cur_n         = 8;
    cur_rank      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: out-of-ring chunk, unused code, count saturation
    issue(ACT_START, 6'd0);
    issue(ACT_RECV, 6'd63);
    issue(ACT_NONE, 6'd63);
    issue(ACT_SENT, 6'd0);
    issue(ACT_RECV, 6'd5);
    repeat (7) issue(ACT_RECV, 6'd5);
    issue(ACT_SENT, 6'd0);

    // zero workers behaves as a ring of one
    set_ring(0, 0);
    issue(ACT_START, 6'd0);
    issue(ACT_SENT, 6'd0);
    issue(ACT_RECV, 6'd0);
    issue(ACT_RECV, 6'd1);
    issue(ACT_NONE, 6'd0);

    // worker count above the maximum, highest rank
    set_ring(127, 63);
    issue(ACT_START, 6'd0);
    issue(ACT_RECV, 6'd60);
    issue(ACT_SENT, 6'd0);

    run_phase(2, 1, 90);
    run_phase(1, 0, 60);
    run_phase(3, 50, 90);
    run_phase(5, 2, 110);
    run_phase(8, 7, 110);
    run_phase(127, 63, 300);
    run_phase(6, 7'h45, 90);
    run_phase(16, 9, 110);
    run_phase(0, 63, 40);
    run_phase(64, 0, 100);

    drain();
    $display("summary: %0d requests over %0d ring settings, %0d results checked",
             requests_sent, settings_used, results_seen);
    $display("summary: %0d sends issued; rings of 1 to %0d workers, ranks inside and past the ring",
             sends_seen, MAX_WORKERS);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
